/* sv/lge_pkg.sv */
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants for the life generation engine: request and
// response items, request codes, configuration indexes and controller states.
// ----------------------------------------------------------------------------
package lge_pkg;

    // default board size
    localparam int DEF_GRID_ROWS = 32;
    localparam int DEF_GRID_COLS = 32;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_SIZE_RESET  = 6'd32;

    // request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_ADVANCE = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] cell_row;
        logic [4:0] cell_col;
        logic       write_alive;
    } lge_req_t;

    typedef struct packed {
        logic read_alive;
        logic was_empty;
    } lge_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_ADV_FILL,
        ST_ADV_RUN
    } lge_state_t;

endpackage

/* sv/life_generation_engine.sv */
// ----------------------------------------------------------------------------
// life_generation_engine
// Game of Life board (B3/S23) held one row per word in a board memory.
// Serves cell writes, cell reads and whole-board advance requests.
// ----------------------------------------------------------------------------
// Cell write or read: the row word is read, then written back or its bit picked;
// advance: one board row read and one written per cycle.
// One item at a time; the input stalls until the result is in the output register.
// Reset: all cells read dead through per-row valid bits, no clearing pass;
// rows_in_use and cols_in_use reset to 32.
module life_generation_engine #(
    parameter int GRID_ROWS = lge_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS = lge_pkg::DEF_GRID_COLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  lge_pkg::lge_req_t                 req_item,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output lge_pkg::lge_rsp_t                 rsp_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lge_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lge_pkg::CFG_W-1:0]         cfg_data
);
    import lge_pkg::*;

    localparam int RIW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int IXW = RIW + 1;
    localparam int LW  = (IXW > CFG_W) ? IXW : CFG_W;
    localparam int CCW = $clog2(GRID_COLS + 1);
    localparam int CLW = (CCW > CFG_W) ? CCW : CFG_W;

    // board memory and per-row valid bits
    logic [GRID_COLS-1:0] board_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] row_valid_reg;
    logic [GRID_COLS-1:0] rd_data_reg;
    logic                 rd_ok_reg;

    logic                 mem_rd_en;
    logic [RIW-1:0]       mem_rd_addr;
    logic                 mem_wr_en;
    logic [RIW-1:0]       mem_wr_addr;
    logic [GRID_COLS-1:0] mem_wr_data;

    // configuration
    logic [CFG_W-1:0] rows_in_use_reg;
    logic [CFG_W-1:0] cols_in_use_reg;

    // controller
    lge_state_t           state_reg, state_next;
    lge_req_t             req_reg, req_next;
    logic [IXW-1:0]       idx_reg, idx_next;
    logic [GRID_COLS-1:0] prior_reg, prior_next;
    logic [GRID_COLS-1:0] cur_reg, cur_next;
    logic                 empty_reg, empty_next;
    logic                 res_pend_reg, res_pend_next;
    lge_rsp_t             res_reg, res_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    lge_rsp_t             rsp_item_reg, rsp_item_next;

    logic [LW-1:0]        row_lim;
    logic [CLW-1:0]       col_lim;
    logic [GRID_COLS-1:0] col_mask;
    logic [GRID_COLS-1:0] col_onehot;
    logic [GRID_COLS-1:0] row_word;
    logic [GRID_COLS-1:0] below_row;
    logic [GRID_COLS-1:0] new_row;
    logic [IXW-1:0]       idx_inc;
    logic [IXW-1:0]       idx_dec;
    logic                 in_area;
    logic                 accept;

    // active size, clipped to the board
    always_comb
    begin
        if (LW'(rows_in_use_reg) < LW'(GRID_ROWS))
            row_lim = LW'(rows_in_use_reg);
        else
            row_lim = LW'(GRID_ROWS);
        if (CLW'(cols_in_use_reg) < CLW'(GRID_COLS))
            col_lim = CLW'(cols_in_use_reg);
        else
            col_lim = CLW'(GRID_COLS);
    end

    // column mask and selected column
    always_comb
    begin
        for (int j = 0; j < GRID_COLS; j++)
        begin
            col_mask[j]   = CLW'(j) < col_lim;
            col_onehot[j] = CLW'(req_reg.cell_col) == CLW'(j);
        end
    end

    assign in_area  = (LW'(req_reg.cell_row) < row_lim) && (CLW'(req_reg.cell_col) < col_lim);
    assign row_word = rd_ok_reg ? rd_data_reg : '0;
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign below_row = (LW'(idx_reg) < row_lim) ? (row_word & col_mask) : '0;

    // rule for the row being rewritten
    lge_row_update #(
        .GRID_COLS (GRID_COLS)
    ) u_row_update (
        .prior_row (prior_reg),
        .cur_row   (cur_reg),
        .below_row (below_row),
        .col_mask  (col_mask),
        .next_row  (new_row)
    );

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE) || res_pend_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;
    assign cfg_ready = 1'b1;

    // next state, memory controls and response path
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        prior_next     = prior_reg;
        cur_next       = cur_reg;
        empty_next     = empty_reg;
        res_pend_next  = res_pend_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = '0;

        // move a finished response into the output register
        if (res_pend_reg && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_valid_next = 1'b1;
            rsp_item_next  = res_reg;
            res_pend_next  = 1'b0;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = req_item;
                    case (req_item.req_type)
                        REQ_WRITE, REQ_READ:
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = RIW'(req_item.cell_row);
                            state_next  = ST_CELL;
                        end
                        REQ_ADVANCE:
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = '0;
                            empty_next  = 1'b1;
                            prior_next  = '0;
                            state_next  = ST_ADV_FILL;
                        end
                        default:
                        begin
                            res_next      = '0;
                            res_pend_next = 1'b1;
                        end
                    endcase
                end
            end

            // row word is back: modify for a write, pick a bit for a read
            ST_CELL:
            begin
                res_next = '0;
                if (req_reg.req_type == REQ_WRITE)
                begin
                    mem_wr_en   = in_area;
                    mem_wr_addr = RIW'(req_reg.cell_row);
                    mem_wr_data = req_reg.write_alive ? (row_word | col_onehot)
                                                      : (row_word & ~col_onehot);
                end
                else
                begin
                    res_next.read_alive = in_area && ((row_word & col_onehot) != '0);
                end
                res_pend_next = 1'b1;
                state_next    = ST_IDLE;
            end

            // row 0 is back, fetch row 1
            ST_ADV_FILL:
            begin
                cur_next    = (row_lim != '0) ? (row_word & col_mask) : '0;
                mem_rd_en   = 1'b1;
                mem_rd_addr = RIW'(IXW'(1));
                idx_next    = IXW'(1);
                state_next  = ST_ADV_RUN;
            end

            // row idx is back; rewrite row idx-1 and fetch row idx+1
            ST_ADV_RUN:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_dec[RIW-1:0];
                mem_wr_data = (LW'(idx_dec) < row_lim) ? new_row : '0;
                empty_next  = empty_reg && (cur_reg == '0);
                prior_next  = cur_reg;
                cur_next    = below_row;
                idx_next    = idx_inc;
                if (idx_inc < IXW'(GRID_ROWS))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_inc[RIW-1:0];
                end
                if (idx_reg == IXW'(GRID_ROWS))
                begin
                    res_next           = '0;
                    res_next.was_empty = empty_reg && (cur_reg == '0);
                    res_pend_next      = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // board memory, synchronous read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            board_mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            rd_data_reg <= board_mem[mem_rd_addr];
    end

    // row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (mem_wr_en)
                row_valid_reg[mem_wr_addr] <= 1'b1;
            if (mem_rd_en)
                rd_ok_reg <= row_valid_reg[mem_rd_addr];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= CFG_SIZE_RESET;
            cols_in_use_reg <= CFG_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_data;
                CFG_COLS_IN_USE: cols_in_use_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            res_pend_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_pend_reg  <= res_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        prior_reg    <= prior_next;
        cur_reg      <= cur_next;
        empty_reg    <= empty_next;
        res_reg      <= res_next;
        rsp_item_reg <= rsp_item_next;
    end

endmodule

/* sv/lge_row_update.sv */
// ----------------------------------------------------------------------------
// lge_row_update
// Applies rule B3/S23 to one row word, given the old rows above and below.
// Columns beyond the active mask and beyond the board edge count as dead.
// ----------------------------------------------------------------------------
module lge_row_update #(
    parameter int GRID_COLS = lge_pkg::DEF_GRID_COLS
) (
    input  logic [GRID_COLS-1:0] prior_row,
    input  logic [GRID_COLS-1:0] cur_row,
    input  logic [GRID_COLS-1:0] below_row,
    input  logic [GRID_COLS-1:0] col_mask,
    output logic [GRID_COLS-1:0] next_row
);
    import lge_pkg::*;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    logic [GRID_COLS+1:0] prior_pad;
    logic [GRID_COLS+1:0] cur_pad;
    logic [GRID_COLS+1:0] below_pad;

    // dead cells on both board edges
    assign prior_pad = {1'b0, prior_row, 1'b0};
    assign cur_pad   = {1'b0, cur_row, 1'b0};
    assign below_pad = {1'b0, below_row, 1'b0};

    // neighbor count and rule, one column each
    always_comb
    begin
        logic [3:0] count;
        for (int j = 0; j < GRID_COLS; j++)
        begin
            count = 4'(prior_pad[j]) + 4'(prior_pad[j+1]) + 4'(prior_pad[j+2])
                  + 4'(cur_pad[j]) + 4'(cur_pad[j+2])
                  + 4'(below_pad[j]) + 4'(below_pad[j+1]) + 4'(below_pad[j+2]);
            next_row[j] = col_mask[j]
                        & ((count == BIRTH_COUNT) | (cur_row[j] & (count == SURVIVE_COUNT)));
        end
    end

endmodule
